FILE: rtl/kfe_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the knapsack fitness evaluator
package kfe_pkg;

	// field widths fixed by the item and result formats
	localparam int IDX_W      = 6;
	localparam int ENTRY_W    = 8;
	localparam int GENOME_W   = 50;
	localparam int SUM_W      = 14;
	localparam int CAP_W      = 14;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = 2 * SUM_W;
	localparam int FRAC_W     = 16;
	localparam int FIT_W      = PROD_W + FRAC_W;
	localparam int DIV_CNT_W  = $clog2(COEF_W);
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// reset values of the configuration registers
	localparam logic [CAP_W-1:0]  CAP_RESET  = 14'd60;
	localparam logic [COEF_W-1:0] COEF_RESET = 16'd6554;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PENALTY  = 8'd1;

	// partial sums handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] value;
		logic [SUM_W-1:0] weight;
	} kfe_link_t;

	// one finished result
	typedef struct packed {
		logic [SUM_W-1:0] total_value;
		logic [SUM_W-1:0] total_weight;
		logic             overweight;
		logic [FIT_W-1:0] fitness;
	} kfe_res_t;

	typedef enum logic [1:0] {
		POST_IDLE,
		POST_MUL,
		POST_DIV,
		POST_DONE
	} post_state_t;

endpackage

FILE: rtl/kfe_if.sv
`timescale 1ns / 1ps
// channel interfaces: command stream, result stream and config write
interface kfe_cmd_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [kfe_pkg::IDX_W-1:0]    item_index;
	logic [kfe_pkg::ENTRY_W-1:0]  item_weight;
	logic [kfe_pkg::ENTRY_W-1:0]  item_price;
	logic [kfe_pkg::GENOME_W-1:0] genome;

	modport source (output valid, action, item_index, item_weight, item_price, genome,
		input ready);
	modport sink (input valid, action, item_index, item_weight, item_price, genome,
		output ready);
endinterface

interface kfe_res_if;
	logic                      valid;
	logic                      ready;
	logic [kfe_pkg::SUM_W-1:0] total_value;
	logic [kfe_pkg::SUM_W-1:0] total_weight;
	logic                      overweight;
	logic [kfe_pkg::FIT_W-1:0] fitness;

	modport source (output valid, total_value, total_weight, overweight, fitness,
		input ready);
	modport sink (input valid, total_value, total_weight, overweight, fitness,
		output ready);
endinterface

interface kfe_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [kfe_pkg::CFG_IDX_W-1:0]  index;
	logic [kfe_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

FILE: rtl/knapsack_fitness_eval_top.sv
`timescale 1ns / 1ps
// top level of the knapsack fitness evaluator
//
// knapsack fitness evaluator. a row of ITEM_COUNT cells holds the weight and
// price of each item; a load transaction (action 0) writes one cell and
// gives no result, and a load to an index at or above ITEM_COUNT is
// dropped. an evaluate transaction (action 1) latches the genome and sends a
// token with zeroed sums down the cell row, one cell per cycle, each cell
// adding its entry when its genome bit is set. the final stage then checks the
// total weight against capacity: within capacity a 14x14 multiply gives
// fitness = value * weight in Q28.16, over capacity a radix-2 restoring divider
// gives penalty_coefficient / (weight - capacity), one quotient bit per cycle.
// an evaluate result passes through the cell row and then the multiply or,
// over capacity, the 16-step divide. one evaluation is in flight
// at a time; cmd.ready returns as soon as the result moves into the output
// register, so the next transaction is taken while that result still waits on
// res.ready. table entries hold nothing meaningful until loaded. config writes
// are always taken and should be made while the block is idle.
module knapsack_fitness_eval_top #(
	parameter int ITEM_COUNT = 50
) (
	input  logic           clk,
	input  logic           arst_n,
	kfe_cmd_if.sink        cmd,
	kfe_res_if.source      res,
	kfe_cfg_if.sink        cfg
);

	// configuration registers
	logic [kfe_pkg::CAP_W-1:0]    cap_q;
	logic [kfe_pkg::COEF_W-1:0]   coef_q;

	// input side control
	logic                         cmd_acc;
	logic                         eval_acc;
	logic                         load_acc;
	logic                         busy_q;

	// chain head, latched genome and cell links
	logic [kfe_pkg::GENOME_W-1:0] genome_q;
	logic                         start_q;
	kfe_pkg::kfe_link_t           link [ITEM_COUNT+1];

	// final stage and output register
	logic                         post_done;
	logic                         take;
	kfe_pkg::kfe_res_t            post_res;
	kfe_pkg::kfe_res_t            res_q;
	logic                         res_valid_q;

	// one evaluation in flight; loads are only taken while idle too
	assign cmd.ready = !busy_q;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign eval_acc  = cmd_acc && (cmd.action == kfe_pkg::ACT_EVAL);
	assign load_acc  = cmd_acc && (cmd.action == kfe_pkg::ACT_LOAD);

	// result moves to the output register when that register is empty or being read
	assign take = post_done && (!res_valid_q || res.ready);

	// config write port, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= kfe_pkg::CAP_RESET;
			coef_q <= kfe_pkg::COEF_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				kfe_pkg::CFG_CAPACITY: cap_q  <= cfg.wdata[kfe_pkg::CAP_W-1:0];
				kfe_pkg::CFG_PENALTY:  coef_q <= cfg.wdata[kfe_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// busy from evaluate acceptance until its result is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= eval_acc;
			if (eval_acc) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			genome_q <= cmd.genome;
		end
	end

	// token enters the row with zeroed sums
	assign link[0].valid  = start_q;
	assign link[0].value  = '0;
	assign link[0].weight = '0;

	for (genvar i = 0; i < ITEM_COUNT; i++) begin : g_cell
		logic ld_en;
		logic sel;

		assign ld_en = load_acc && (cmd.item_index == kfe_pkg::IDX_W'(i));

		// genome bits beyond the field width never select a cell
		if (i < kfe_pkg::GENOME_W) begin : g_sel
			assign sel = genome_q[i];
		end else begin : g_nosel
			assign sel = 1'b0;
		end

		kfe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ld_en     (ld_en),
			.ld_weight (cmd.item_weight),
			.ld_price  (cmd.item_price),
			.sel       (sel),
			.link_i    (link[i]),
			.link_o    (link[i+1])
		);
	end

	kfe_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.tail     (link[ITEM_COUNT]),
		.capacity (cap_q),
		.coef     (coef_q),
		.take     (take),
		.done     (post_done),
		.res      (post_res)
	);

	// output register, decouples the result transaction from the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= post_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.total_value  = res_q.total_value;
	assign res.total_weight = res_q.total_weight;
	assign res.overweight   = res_q.overweight;
	assign res.fitness      = res_q.fitness;

endmodule

FILE: rtl/kfe_cell.sv
`timescale 1ns / 1ps
// one item cell: holds a weight and price entry and adds it to the passing sums
module kfe_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ld_en,
	input  logic [kfe_pkg::ENTRY_W-1:0] ld_weight,
	input  logic [kfe_pkg::ENTRY_W-1:0] ld_price,
	input  logic                        sel,
	input  kfe_pkg::kfe_link_t          link_i,
	output kfe_pkg::kfe_link_t          link_o
);

	logic [kfe_pkg::ENTRY_W-1:0] weight_q;
	logic [kfe_pkg::ENTRY_W-1:0] price_q;
	logic [kfe_pkg::ENTRY_W-1:0] add_w;
	logic [kfe_pkg::ENTRY_W-1:0] add_p;
	logic                        valid_q;
	logic [kfe_pkg::SUM_W-1:0]   value_q;
	logic [kfe_pkg::SUM_W-1:0]   wsum_q;

	always_ff @(posedge clk) begin
		if (ld_en) begin
			weight_q <= ld_weight;
			price_q  <= ld_price;
		end
	end

	assign add_w = sel ? weight_q : '0;
	assign add_p = sel ? price_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= link_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= link_i.value
			+ {{(kfe_pkg::SUM_W-kfe_pkg::ENTRY_W){1'b0}}, add_p};
		wsum_q  <= link_i.weight
			+ {{(kfe_pkg::SUM_W-kfe_pkg::ENTRY_W){1'b0}}, add_w};
	end

	assign link_o = {valid_q, value_q, wsum_q};

endmodule

FILE: rtl/kfe_post.sv
`timescale 1ns / 1ps
// final stage: capacity check, product or penalty division, result hold
module kfe_post (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kfe_pkg::kfe_link_t          tail,
	input  logic [kfe_pkg::CAP_W-1:0]   capacity,
	input  logic [kfe_pkg::COEF_W-1:0]  coef,
	input  logic                        take,
	output logic                        done,
	output kfe_pkg::kfe_res_t           res
);

	kfe_pkg::post_state_t state_q;
	kfe_pkg::post_state_t state_nxt;

	logic [kfe_pkg::SUM_W-1:0]     val_q;
	logic [kfe_pkg::SUM_W-1:0]     wt_q;
	logic                          over_q;
	logic [kfe_pkg::SUM_W-1:0]     excess_q;
	logic [kfe_pkg::PROD_W-1:0]    prod_q;
	logic [kfe_pkg::SUM_W-1:0]     rem_q;
	logic [kfe_pkg::COEF_W-1:0]    dvd_q;
	logic [kfe_pkg::DIV_CNT_W-1:0] cnt_q;

	logic [kfe_pkg::SUM_W:0]       trial;
	logic                          fits;

	// restoring divider step, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[kfe_pkg::COEF_W-1]};
	assign fits  = trial >= {1'b0, excess_q};

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			kfe_pkg::POST_IDLE: if (tail.valid) begin
				state_nxt = (tail.weight > capacity) ? kfe_pkg::POST_DIV : kfe_pkg::POST_MUL;
			end
			kfe_pkg::POST_MUL:  state_nxt = kfe_pkg::POST_DONE;
			kfe_pkg::POST_DIV:  if (cnt_q == '0) begin
				state_nxt = kfe_pkg::POST_DONE;
			end
			kfe_pkg::POST_DONE: if (take) begin
				state_nxt = kfe_pkg::POST_IDLE;
			end
			default:            state_nxt = kfe_pkg::POST_IDLE;
		endcase
	end

	always_comb begin
		done = 1'b0;
		unique case (state_q)
			kfe_pkg::POST_DONE: done = 1'b1;
			default:            done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kfe_pkg::POST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			kfe_pkg::POST_IDLE: if (tail.valid) begin
				val_q    <= tail.value;
				wt_q     <= tail.weight;
				over_q   <= tail.weight > capacity;
				excess_q <= tail.weight - capacity;
				rem_q    <= '0;
				dvd_q    <= coef;
				cnt_q    <= '1;
			end
			kfe_pkg::POST_MUL: begin
				prod_q <= kfe_pkg::PROD_W'(val_q) * kfe_pkg::PROD_W'(wt_q);
			end
			kfe_pkg::POST_DIV: begin
				rem_q <= fits ? kfe_pkg::SUM_W'(trial - {1'b0, excess_q})
					: trial[kfe_pkg::SUM_W-1:0];
				dvd_q <= {dvd_q[kfe_pkg::COEF_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign res.total_value  = val_q;
	assign res.total_weight = wt_q;
	assign res.overweight   = over_q;
	assign res.fitness      = over_q
		? {{(kfe_pkg::FIT_W-kfe_pkg::COEF_W){1'b0}}, dvd_q}
		: {prod_q, {kfe_pkg::FRAC_W{1'b0}}};

endmodule

FILE: rtl/kfe_checker.sv
`timescale 1ns / 1ps
// port-level checks for the knapsack fitness evaluator and their binding
module kfe_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_action,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      out_overweight,
	input logic [kfe_pkg::FIT_W-1:0] out_fitness,
	input logic                      cfg_ready
);

	// an evaluate transaction closes the command side for the next cycle
	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_action == kfe_pkg::ACT_EVAL) |=> !in_ready)
		else $error("command ready stayed high after an evaluate transaction");

	// a load transaction never makes the block busy
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_action == kfe_pkg::ACT_LOAD) |=> in_ready)
		else $error("command ready dropped after a load transaction");

	// within capacity the fitness is a whole number in Q.16
	a_fit_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_overweight) |-> (out_fitness[kfe_pkg::FRAC_W-1:0] == '0))
		else $error("fraction bits set on a fitness within capacity");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_fitness)))
		else $error("stalled result changed");

	// config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config ready low");

endmodule

bind knapsack_fitness_eval_top kfe_checker u_kfe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (cmd.valid),
	.in_ready       (cmd.ready),
	.in_action      (cmd.action),
	.out_valid      (res.valid),
	.out_ready      (res.ready),
	.out_overweight (res.overweight),
	.out_fitness    (res.fitness),
	.cfg_ready      (cfg.ready)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the knapsack fitness evaluator top level
module tb_top;

	localparam int ITEM_COUNT = 50;

	// chance in a hundred that a side sits out a cycle
	localparam int IDLE_PCT = 34;

	// an evaluate runs through the cell row and the divide; loads leave no result
	// behind, so give the cell row time to go quiet before touching registers
	localparam int DRAIN_CYCLES = ITEM_COUNT + 24;

	// register indexes the block does not decode, writes there must do nothing
	localparam logic [kfe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
	localparam logic [kfe_pkg::CFG_IDX_W-1:0] CFG_LAST  = 8'hFF;

	// window of accepted commands during which neither side idles
	localparam int CALM_FIRST = 450;
	localparam int CALM_LAST  = 620;

	// long result hold-offs, triggered by accepted command count
	localparam int HOLD_AT_A  = 330;
	localparam int HOLD_LEN_A = 400;
	localparam int HOLD_AT_B  = 760;
	localparam int HOLD_LEN_B = 250;

	typedef struct packed {
		logic                         action;
		logic [kfe_pkg::IDX_W-1:0]    item_index;
		logic [kfe_pkg::ENTRY_W-1:0]  item_weight;
		logic [kfe_pkg::ENTRY_W-1:0]  item_price;
		logic [kfe_pkg::GENOME_W-1:0] genome;
	} kfe_cmd_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	kfe_cmd_if cmd_if ();
	kfe_res_if res_if ();
	kfe_cfg_if cfg_if ();

	knapsack_fitness_eval_top #(
		.ITEM_COUNT(ITEM_COUNT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// testbench-side drive registers, known from time zero
	// ------------------------------------------------------------------
	kfe_cmd_t                       cmd_cur     = '0;
	logic                           cmd_valid_r = 1'b0;
	logic                           res_ready_r = 1'b0;
	logic                           cfg_valid_r = 1'b0;
	logic [kfe_pkg::CFG_IDX_W-1:0]  cfg_index_r = '0;
	logic [kfe_pkg::CFG_DATA_W-1:0] cfg_wdata_r = '0;

	assign cmd_if.valid       = cmd_valid_r;
	assign cmd_if.action      = cmd_cur.action;
	assign cmd_if.item_index  = cmd_cur.item_index;
	assign cmd_if.item_weight = cmd_cur.item_weight;
	assign cmd_if.item_price  = cmd_cur.item_price;
	assign cmd_if.genome      = cmd_cur.genome;
	assign res_if.ready       = res_ready_r;
	assign cfg_if.valid       = cfg_valid_r;
	assign cfg_if.index       = cfg_index_r;
	assign cfg_if.wdata       = cfg_wdata_r;

	// ------------------------------------------------------------------
	// predictor state: tables and registers as the block should hold them
	// ------------------------------------------------------------------
	logic [kfe_pkg::ENTRY_W-1:0] weight_by_item [ITEM_COUNT];
	logic [kfe_pkg::ENTRY_W-1:0] price_by_item  [ITEM_COUNT];
	logic [kfe_pkg::CAP_W-1:0]   cap_now  = kfe_pkg::CAP_RESET;
	logic [kfe_pkg::COEF_W-1:0]  coef_now = kfe_pkg::COEF_RESET;

	kfe_pkg::kfe_res_t fitness_due_q [$];   // scores still owed by the block, oldest first
	kfe_cmd_t          cmd_backlog_q [$];   // commands waiting for the driver

	// entries the stimulus has loaded so far; genomes never pick anything else
	logic [ITEM_COUNT-1:0] loaded_mask = '0;

	int   err_count     = 0;
	int   cmd_taken_cnt = 0;
	logic cmd_took      = 1'b0;

	int hold_left  = 0;
	int holds_done = 0;

	function automatic bit calm_now();
		return cmd_taken_cnt >= CALM_FIRST && cmd_taken_cnt < CALM_LAST;
	endfunction

	// value and weight sums of the picked items, then the fitness:
	// product of the two in Q28.16 within capacity, coefficient over excess past it
	function automatic kfe_pkg::kfe_res_t score_genome(
			input logic [kfe_pkg::GENOME_W-1:0] picks);
		kfe_pkg::kfe_res_t verdict;
		int unsigned       v;
		int unsigned       w;
		int                i;
		v = 0;
		w = 0;
		for (i = 0; i < ITEM_COUNT; i++)
			if (picks[i]) begin
				v += price_by_item[i];
				w += weight_by_item[i];
			end
		verdict.total_value  = v[kfe_pkg::SUM_W-1:0];
		verdict.total_weight = w[kfe_pkg::SUM_W-1:0];
		verdict.overweight   = w > cap_now;
		if (w > cap_now)
			verdict.fitness = kfe_pkg::FIT_W'(coef_now / (w - cap_now));
		else
			verdict.fitness = kfe_pkg::FIT_W'(v * w) << kfe_pkg::FRAC_W;
		return verdict;
	endfunction

	task automatic compare_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// monitor: samples every handshake at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_took <= cmd_if.valid && cmd_if.ready;

			// result transaction against the oldest owed score
			if (res_if.valid && res_if.ready) begin
				if (fitness_due_q.size() == 0) begin
					err_count++;
					$display({"%0t: unexpected result, expected nothing, ",
						"got value %0d weight %0d over %0d fitness %0d"},
						$time, res_if.total_value, res_if.total_weight,
						res_if.overweight, res_if.fitness);
				end else begin
					kfe_pkg::kfe_res_t want;
					want = fitness_due_q.pop_front();
					compare_field("total_value", 64'(want.total_value),
						64'(res_if.total_value));
					compare_field("total_weight", 64'(want.total_weight),
						64'(res_if.total_weight));
					compare_field("overweight", 64'(want.overweight),
						64'(res_if.overweight));
					compare_field("fitness", 64'(want.fitness), 64'(res_if.fitness));
				end
			end

			// register writes, unknown indexes fall through untouched
			if (cfg_if.valid && cfg_if.ready) begin
				if (cfg_if.index == kfe_pkg::CFG_CAPACITY)
					cap_now <= cfg_if.wdata[kfe_pkg::CAP_W-1:0];
				else if (cfg_if.index == kfe_pkg::CFG_PENALTY)
					coef_now <= cfg_if.wdata;
			end

			// command transaction: score an evaluate now, or update the tables
			if (cmd_if.valid && cmd_if.ready) begin
				cmd_taken_cnt <= cmd_taken_cnt + 1;
				if (cmd_if.action == kfe_pkg::ACT_EVAL)
					fitness_due_q.push_back(score_genome(cmd_if.genome));
				else if (cmd_if.item_index < ITEM_COUNT) begin
					weight_by_item[cmd_if.item_index] <= cmd_if.item_weight;
					price_by_item[cmd_if.item_index]  <= cmd_if.item_price;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// command driver: new transaction only once the last one was taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid_r || cmd_took)) begin
			if (cmd_backlog_q.size() != 0 && (calm_now() || $urandom_range(99) >= IDLE_PCT)) begin
				cmd_cur     <= cmd_backlog_q.pop_front();
				cmd_valid_r <= 1'b1;
			end else
				cmd_valid_r <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// result ready: random stalls plus two long hold-offs that back the
	// block up into its command input
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left == 0 && holds_done == 0 && cmd_taken_cnt >= HOLD_AT_A) begin
			hold_left  = HOLD_LEN_A;
			holds_done = 1;
		end else if (hold_left == 0 && holds_done == 1 && cmd_taken_cnt >= HOLD_AT_B) begin
			hold_left  = HOLD_LEN_B;
			holds_done = 2;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			res_ready_r <= 1'b0;
		end else
			res_ready_r <= calm_now() || $urandom_range(99) >= IDLE_PCT;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [kfe_pkg::ENTRY_W-1:0] rand_entry();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return kfe_pkg::ENTRY_W'($urandom);
		endcase
	endfunction

	// mix of dense, sparse and one- or two-item picks, limited to loaded entries
	function automatic logic [kfe_pkg::GENOME_W-1:0] rand_genome();
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] g;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(4))
			0: g = a;
			1: g = a & b;
			2: g = a & b & c;
			3: g = 64'd1 << $urandom_range(ITEM_COUNT - 1);
			default: g = (64'd1 << $urandom_range(ITEM_COUNT - 1))
				| (64'd1 << $urandom_range(ITEM_COUNT - 1));
		endcase
		return kfe_pkg::GENOME_W'(g) & kfe_pkg::GENOME_W'(loaded_mask);
	endfunction

	task automatic queue_load(input int unsigned slot,
			input logic [kfe_pkg::ENTRY_W-1:0] wt,
			input logic [kfe_pkg::ENTRY_W-1:0] pr);
		kfe_cmd_t c;
		c.action      = kfe_pkg::ACT_LOAD;
		c.item_index  = kfe_pkg::IDX_W'(slot);
		c.item_weight = wt;
		c.item_price  = pr;
		c.genome      = kfe_pkg::GENOME_W'({$urandom, $urandom});   // don't care on a load
		cmd_backlog_q.push_back(c);
		if (slot < ITEM_COUNT)
			loaded_mask[slot] = 1'b1;
	endtask

	task automatic queue_eval(input logic [kfe_pkg::GENOME_W-1:0] picks);
		kfe_cmd_t c;
		c.action      = kfe_pkg::ACT_EVAL;
		c.item_index  = kfe_pkg::IDX_W'($urandom);          // don't care on an evaluate
		c.item_weight = kfe_pkg::ENTRY_W'($urandom);
		c.item_price  = kfe_pkg::ENTRY_W'($urandom);
		c.genome      = picks;
		cmd_backlog_q.push_back(c);
	endtask

	// mostly evaluates, the rest reloads with now and then an index past the table
	task automatic queue_random(input int n);
		int k;
		for (k = 0; k < n; k++)
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(9) == 0)
					queue_load($urandom_range(63, ITEM_COUNT), rand_entry(), rand_entry());
				else
					queue_load($urandom_range(ITEM_COUNT - 1), rand_entry(), rand_entry());
			end else
				queue_eval(rand_genome());
	endtask

	// wait until every command is taken and every score has come back, then drain
	task automatic settle();
		do
			@(negedge clk);
		while (cmd_backlog_q.size() != 0 || cmd_valid_r || fitness_due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [kfe_pkg::CFG_IDX_W-1:0] idx,
			input logic [kfe_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_index_r = idx;
		cfg_wdata_r = data;
		cfg_valid_r = 1'b1;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid_r = 1'b0;
	endtask

	task automatic run_phase(input logic [kfe_pkg::CFG_DATA_W-1:0] cap,
			input logic [kfe_pkg::CFG_DATA_W-1:0] coef, input bit lead_full, input int n);
		write_reg(kfe_pkg::CFG_CAPACITY, cap);
		write_reg(kfe_pkg::CFG_PENALTY, coef);
		if (lead_full)
			queue_eval({kfe_pkg::GENOME_W{1'b1}});
		queue_random(n);
		settle();
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int k;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset register values (capacity 60, about 0.1)
		queue_load(0, 8'hFF, 8'hFF);
		queue_load(1, 8'h00, 8'h00);
		queue_load(2, 8'hAA, 8'h55);
		queue_load(3, 8'h55, 8'hAA);
		queue_load(4, 8'd60, 8'd200);
		queue_load(5, 8'd9, 8'd9);
		queue_load(5, 8'd61, 8'd3);              // overwrite of an entry
		queue_load(ITEM_COUNT, 8'h11, 8'h22);    // first index past the table, dropped
		queue_load(63, 8'hFF, 8'hFF);            // all index bits set, dropped
		queue_eval('0);                          // empty pick
		queue_eval(kfe_pkg::GENOME_W'(1) << 1);  // zero weight, zero price
		queue_eval(kfe_pkg::GENOME_W'(1) << 4);  // weight equals capacity
		queue_eval(kfe_pkg::GENOME_W'(1) << 5);  // excess of one, fitness is the coefficient
		queue_eval(kfe_pkg::GENOME_W'(1) << 0);  // heavy single item
		queue_eval(kfe_pkg::GENOME_W'(12));      // two items summing to 255
		queue_eval(kfe_pkg::GENOME_W'(18));      // zero-weight item plus the at-capacity one
		queue_eval(kfe_pkg::GENOME_W'(63));      // every loaded entry
		settle();

		// capacity written with all ones (upper bits drop), zero penalty,
		// plus writes to indexes that must be ignored
		write_reg(kfe_pkg::CFG_CAPACITY, 16'hFFFF);
		write_reg(kfe_pkg::CFG_PENALTY, 16'h0000);
		write_reg(CFG_SPARE, 16'h1234);
		write_reg(CFG_LAST, 16'hFFFF);
		for (k = 0; k < ITEM_COUNT; k++)
			queue_load(k, 8'hFF, 8'hFF);
		queue_eval({kfe_pkg::GENOME_W{1'b1}});   // largest sums, largest fitness
		settle();

		// full table right at the capacity limit, then one over it
		run_phase(16'd12750, 16'hFFFF, 1'b1, 0);
		run_phase(16'd12749, 16'hFFFF, 1'b1, 150);

		// random phases across the register range
		run_phase(16'd0, 16'd1, 1'b0, 150);
		run_phase(16'd60, 16'd6554, 1'b0, 150);
		run_phase(kfe_pkg::CFG_DATA_W'($urandom_range(12750)),
			kfe_pkg::CFG_DATA_W'($urandom), 1'b1, 150);
		run_phase(16'd2000, kfe_pkg::CFG_DATA_W'($urandom), 1'b0, 150);

		if (err_count == 0)
			$display("knapsack_fitness_eval_top test passed");
		else
			$display("knapsack_fitness_eval_top test failed");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("knapsack_fitness_eval_top test failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/kfe_pkg.sv
rtl/kfe_if.sv
rtl/kfe_cell.sv
rtl/kfe_post.sv
rtl/knapsack_fitness_eval_top.sv
rtl/kfe_checker.sv
tb/sv/tb_top.sv
